@@ hw/rtl/dla_pkg.sv @@
package dla_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN
    } t_state;

    typedef struct packed {
        logic [47:0] owner;
        logic [15:0] expiry;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    localparam logic [1:0] KIND_OFFER = 2'd0;
    localparam logic [1:0] KIND_ACK   = 2'd1;
    localparam logic [1:0] KIND_NAK   = 2'd2;

    localparam logic [7:0] MSG_DISCOVER = 8'd1;
    localparam logic [7:0] MSG_REQUEST  = 8'd3;

    localparam logic REG_SERVER_IP   = 1'b0;
    localparam logic REG_LEASE_COUNT = 1'b1;

    localparam logic [31:0] SERVER_IP_RST   = 32'hC0A8_0101;
    localparam logic [4:0]  LEASE_COUNT_RST = 5'd16;
    localparam logic [31:0] SUBNET_MASK     = 32'hFFFF_FF00;
    localparam logic [31:0] LEASE_MS        = 32'd3600000;
    localparam logic [15:0] STAMP_LOW       = 16'hFFFF;
    localparam int          SLOT_LIMIT      = 254;

endpackage

@@ hw/rtl/dla_ram.sv @@
module dla_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

@@ hw/rtl/dhcp_lease_allocator.sv @@
// DHCP lease table: takes one parsed message per request (start while busy is
// low) and returns exactly one reply (offer, ack or nak) on the o_ result
// ports, marked by o_valid for a single cycle; the receiver cannot stall, so
// capture the reply in the cycle o_valid is high. Refused requests (other
// message types, a request with no IP, a foreign subnet or a slot out of
// range) reply in the cycle after acceptance and never raise busy. Otherwise
// the owner/expiry entry of the addressed slot is read from the lease RAM
// into its output register, and the reply is registered from that read; a
// discover that finds the slot taken scans the table from slot 0 at one slot
// per cycle. The RAM read port sets that scan rate. The table reads as free
// right after reset (per-slot valid bits), so no clearing pass is needed.
// Write configuration only while busy is low and no reply is pending.
module dhcp_lease_allocator #(
    parameter int MAX_LEASES = 16,
    parameter int BASE_OCTET = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [7:0]  i_msg_type,
    input  logic        i_has_requested_ip,
    input  logic [31:0] i_requested_ip,
    input  logic [47:0] i_client_mac,
    input  logic [31:0] i_now_ms,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    output logic        o_valid,
    output logic [1:0]  o_reply_kind,
    output logic [31:0] o_assigned_ip,
    output logic [3:0]  o_lease_slot
);

    localparam int IW  = (MAX_LEASES > 1) ? $clog2(MAX_LEASES) : 1;
    localparam int LIM = (MAX_LEASES < dla_pkg::SLOT_LIMIT - BASE_OCTET)
                         ? MAX_LEASES : dla_pkg::SLOT_LIMIT - BASE_OCTET;
    localparam logic [7:0] BASE8 = 8'(BASE_OCTET);
    localparam logic [7:0] LIM8  = 8'(LIM);

    dla_pkg::t_state r_state, n_state;

    // configuration
    logic [31:0] r_server_ip;
    logic [4:0]  r_lease_count;

    // request held for the table pass
    logic [47:0]     r_mac;
    logic [31:0]     r_now;
    logic            r_is_req;
    logic [IW-1:0]   r_slot, n_slot;

    // table
    logic [MAX_LEASES-1:0] r_vld;
    logic                  ram_we, ram_re;
    logic [IW-1:0]         ram_waddr, ram_raddr;
    dla_pkg::t_entry       ram_wdata, cur;
    logic [dla_pkg::ENTRY_W-1:0] ram_rdata;

    // reply
    logic        n_valid;
    logic [1:0]  r_kind, n_kind;
    logic [7:0]  r_rslot, n_rslot;

    // combinational helpers
    logic [7:0]  slots_n, oct, d_slot, q_slot, next8;
    logic        q_ok, cur_expired, owner_mine, owner_free;
    logic [31:0] stamp_diff, new_end;

    // clamp slot count to [1, LIM]
    always_comb begin
        slots_n = 8'(r_lease_count);
        if (slots_n == 8'd0) begin
            slots_n = 8'd1;
        end
        if (slots_n > LIM8) begin
            slots_n = LIM8;
        end
    end

    always_comb begin
        oct    = i_requested_ip[7:0];
        d_slot = (i_has_requested_ip && (oct >= BASE8)) ? (oct - BASE8) : 8'd0;
        if (d_slot >= slots_n) begin
            d_slot = 8'd0;
        end
        q_slot = oct - BASE8;
        q_ok   = i_has_requested_ip
                 && (((i_requested_ip ^ r_server_ip) & dla_pkg::SUBNET_MASK) == 32'd0)
                 && (q_slot < slots_n);
    end

    // a never-written slot reads as free with a zero stamp
    assign cur         = r_vld[r_slot] ? dla_pkg::t_entry'(ram_rdata) : '0;
    assign owner_mine  = (cur.owner == r_mac);
    assign owner_free  = (cur.owner == 48'd0);
    assign stamp_diff  = {cur.expiry, dla_pkg::STAMP_LOW} - r_now;
    assign cur_expired = stamp_diff[31];
    assign new_end     = r_now + dla_pkg::LEASE_MS;
    assign next8       = 8'(r_slot) + 8'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= dla_pkg::ST_IDLE;
            r_server_ip   <= dla_pkg::SERVER_IP_RST;
            r_lease_count <= dla_pkg::LEASE_COUNT_RST;
            r_vld         <= '0;
            o_valid       <= 1'b0;
        end else begin
            r_state <= n_state;
            o_valid <= n_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    dla_pkg::REG_SERVER_IP:   r_server_ip   <= i_cfg_data;
                    dla_pkg::REG_LEASE_COUNT: r_lease_count <= i_cfg_data[4:0];
                    default: ;
                endcase
            end
            if (ram_we) begin
                r_vld[ram_waddr] <= 1'b1;
            end
        end
    end

    // payload: no reset
    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_mac    <= i_client_mac;
            r_now    <= i_now_ms;
            r_is_req <= (i_msg_type == dla_pkg::MSG_REQUEST);
        end
        r_slot  <= n_slot;
        r_kind  <= n_kind;
        r_rslot <= n_rslot;
    end

    always_comb begin
        n_state   = r_state;
        n_slot    = r_slot;
        n_valid   = 1'b0;
        n_kind    = r_kind;
        n_rslot   = r_rslot;
        ram_re    = 1'b0;
        ram_raddr = r_slot;
        ram_we    = 1'b0;
        ram_waddr = r_slot;
        ram_wdata = cur;
        unique case (r_state)
            dla_pkg::ST_IDLE: begin
                if (start) begin
                    if (i_msg_type == dla_pkg::MSG_DISCOVER) begin
                        n_slot    = IW'(d_slot);
                        ram_re    = 1'b1;
                        ram_raddr = IW'(d_slot);
                        n_state   = dla_pkg::ST_CHECK;
                    end else if ((i_msg_type == dla_pkg::MSG_REQUEST) && q_ok) begin
                        n_slot    = IW'(q_slot);
                        ram_re    = 1'b1;
                        ram_raddr = IW'(q_slot);
                        n_state   = dla_pkg::ST_CHECK;
                    end else begin
                        // refuse at once, table untouched
                        n_valid = 1'b1;
                        n_kind  = dla_pkg::KIND_NAK;
                        n_rslot = 8'd0;
                    end
                end
            end
            dla_pkg::ST_CHECK: begin
                if (r_is_req) begin
                    n_state = dla_pkg::ST_IDLE;
                    n_valid = 1'b1;
                    n_kind  = dla_pkg::KIND_NAK;
                    n_rslot = 8'd0;
                    if (owner_mine || owner_free) begin
                        // claim or confirm; stamp only with a nonzero server octet
                        ram_we          = 1'b1;
                        ram_wdata.owner = r_mac;
                        if (r_server_ip[7:0] != 8'd0) begin
                            ram_wdata.expiry = new_end[31:16];
                            n_kind           = dla_pkg::KIND_ACK;
                            n_rslot          = 8'(r_slot);
                        end
                    end
                end else if (owner_mine || owner_free) begin
                    n_state = dla_pkg::ST_IDLE;
                    n_valid = 1'b1;
                    n_kind  = dla_pkg::KIND_OFFER;
                    n_rslot = 8'(r_slot);
                end else begin
                    // slot taken: scan from slot 0
                    n_slot    = '0;
                    ram_re    = 1'b1;
                    ram_raddr = '0;
                    n_state   = dla_pkg::ST_SCAN;
                end
            end
            dla_pkg::ST_SCAN: begin
                if (owner_mine || cur_expired) begin
                    if (!owner_mine) begin
                        // reclaim the expired slot, keep its stamp
                        ram_we          = 1'b1;
                        ram_wdata.owner = 48'd0;
                    end
                    n_state = dla_pkg::ST_IDLE;
                    n_valid = 1'b1;
                    n_kind  = dla_pkg::KIND_OFFER;
                    n_rslot = 8'(r_slot);
                end else if (next8 >= slots_n) begin
                    n_state = dla_pkg::ST_IDLE;
                    n_valid = 1'b1;
                    n_kind  = dla_pkg::KIND_NAK;
                    n_rslot = 8'd0;
                end else begin
                    // advance one slot per cycle
                    n_slot    = IW'(next8);
                    ram_re    = 1'b1;
                    ram_raddr = IW'(next8);
                end
            end
            default: n_state = dla_pkg::ST_IDLE;
        endcase
    end

    dla_ram #(
        .WIDTH (dla_pkg::ENTRY_W),
        .DEPTH (MAX_LEASES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign busy          = (r_state != dla_pkg::ST_IDLE);
    assign o_reply_kind  = r_kind;
    assign o_lease_slot  = r_rslot[3:0];
    assign o_assigned_ip = (r_kind == dla_pkg::KIND_NAK) ? r_server_ip
                           : {r_server_ip[31:8], BASE8 + r_rslot};

endmodule

@@ tb/sv/dla_reply_checker.sv @@
`timescale 1ns / 100ps

module dla_reply_checker #(
    parameter int MAX_LEASES = 16,
    parameter int BASE_OCTET = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic [7:0]  i_msg_type,
    input  logic        i_has_requested_ip,
    input  logic [31:0] i_requested_ip,
    input  logic [47:0] i_client_mac,
    input  logic [31:0] i_now_ms,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        i_valid,
    input  logic [1:0]  i_reply_kind,
    input  logic [31:0] i_assigned_ip,
    input  logic [3:0]  i_lease_slot,
    output int          o_pending,
    output int          o_errors
);

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] ip;
        logic [3:0]  slot;
    } t_reply;

    logic [47:0] owner_mac    [MAX_LEASES];
    logic [15:0] expiry_stamp [MAX_LEASES];
    logic [31:0] server_ip;
    logic [4:0]  lease_count;
    t_reply      replies_due  [$];
    int          mismatch_count = 0;

    function automatic int unsigned active_slots();
        int unsigned n;
        n = lease_count;
        if (n < 1) n = 1;
        if (n > MAX_LEASES) n = MAX_LEASES;
        if (n > dla_pkg::SLOT_LIMIT - BASE_OCTET) n = dla_pkg::SLOT_LIMIT - BASE_OCTET;
        return n;
    endfunction

    // A lease has lapsed once its end stamp lies behind the current time.
    function automatic logic lease_lapsed(int unsigned idx, logic [31:0] now);
        logic [31:0] margin;
        margin = {expiry_stamp[idx], dla_pkg::STAMP_LOW} - now;
        return margin[31];
    endfunction

    function automatic t_reply predict_reply(logic [7:0] msg, logic has_ip,
                                             logic [31:0] req, logic [47:0] mac,
                                             logic [31:0] now);
        int unsigned n;
        int unsigned slot;
        logic [7:0]  oct;
        logic [1:0]  kind;
        logic        found;
        logic        ok;
        logic [31:0] due;
        t_reply      r;
        n    = active_slots();
        oct  = req[7:0];
        slot = 0;
        kind = dla_pkg::KIND_NAK;
        if (msg == dla_pkg::MSG_DISCOVER) begin
            found = 1'b0;
            if (has_ip && oct >= BASE_OCTET) slot = oct - BASE_OCTET;
            if (slot >= n) slot = 0;
            if (owner_mac[slot] == mac || owner_mac[slot] == '0) begin
                found = 1'b1;
            end else begin
                for (int unsigned i = 0; i < n && !found; i++) begin
                    if (owner_mac[i] == mac) begin
                        found = 1'b1;
                        slot  = i;
                    end else if (lease_lapsed(i, now)) begin
                        owner_mac[i] = '0;
                        found        = 1'b1;
                        slot         = i;
                    end
                end
            end
            if (found) kind = dla_pkg::KIND_OFFER;
        end else if (msg == dla_pkg::MSG_REQUEST) begin
            ok   = has_ip && (((req ^ server_ip) & dla_pkg::SUBNET_MASK) == '0);
            slot = 8'(oct - BASE_OCTET);
            if (slot >= n) ok = 1'b0;
            if (ok) begin
                if (owner_mac[slot] == '0) owner_mac[slot] = mac;
                else if (owner_mac[slot] != mac) ok = 1'b0;
            end
            if (ok && server_ip[7:0] != 8'd0) begin
                due                = now + dla_pkg::LEASE_MS;
                expiry_stamp[slot] = due[31:16];
                kind               = dla_pkg::KIND_ACK;
            end
        end
        r.kind = kind;
        if (kind == dla_pkg::KIND_NAK) begin
            r.ip   = server_ip;
            r.slot = '0;
        end else begin
            r.ip   = {server_ip[31:8], 8'(BASE_OCTET + slot)};
            r.slot = 4'(slot);
        end
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_reply want;
        t_reply got;
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_LEASES; i++) begin
                owner_mac[i]    = '0;
                expiry_stamp[i] = '0;
            end
            server_ip   = dla_pkg::SERVER_IP_RST;
            lease_count = dla_pkg::LEASE_COUNT_RST;
            replies_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    dla_pkg::REG_SERVER_IP:   server_ip   = i_cfg_data;
                    dla_pkg::REG_LEASE_COUNT: lease_count = i_cfg_data[4:0];
                    default: ;
                endcase
            end
            if (i_valid) begin
                got = {i_reply_kind, i_assigned_ip, i_lease_slot};
                if (replies_due.size() == 0) begin
                    if (mismatch_count < 10)
                        $display("%0t: reply with none pending: kind %0d ip %h slot %0d",
                                 $realtime, got.kind, got.ip, got.slot);
                    mismatch_count++;
                end else begin
                    want = replies_due.pop_front();
                    if (want != got) begin
                        if (mismatch_count < 10)
                            $display({"%0t: reply mismatch: kind exp %0d got %0d, ",
                                      "ip exp %h got %h, slot exp %0d got %0d"},
                                     $realtime, want.kind, got.kind, want.ip, got.ip,
                                     want.slot, got.slot);
                        mismatch_count++;
                    end
                end
            end
            if (i_start && !i_busy)
                replies_due.push_back(predict_reply(i_msg_type, i_has_requested_ip,
                                                    i_requested_ip, i_client_mac,
                                                    i_now_ms));
        end
        o_pending <= replies_due.size();
        o_errors  <= mismatch_count;
    end

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps

// Top of the lease allocator bench: makes the message stream, writes the
// server registers between phases and gives the verdict. All prediction and
// comparison sits in the reply checker beside the block.
module tb;

    localparam int MAX_LEASES  = 16;
    localparam int BASE_OCTET  = 16;
    // Cycles without any request or reply before the run is called hung.
    localparam int STALL_LIMIT = 2000;
    // Tail wait, sized from the slot count to cover a full discover scan.
    localparam int TAIL_CYCLES = MAX_LEASES + 4;

    localparam logic [47:0] MAC_A = 48'h02_00_5E_00_00_01;
    localparam logic [47:0] MAC_B = 48'h02_00_5E_00_00_02;
    localparam logic [47:0] MAC_C = 48'hFF_FF_FF_FF_FF_FF;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [7:0]  i_msg_type;
    logic        i_has_requested_ip;
    logic [31:0] i_requested_ip;
    logic [47:0] i_client_mac;
    logic [31:0] i_now_ms;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [31:0] i_cfg_data;
    logic        o_valid;
    logic [1:0]  o_reply_kind;
    logic [31:0] o_assigned_ip;
    logic [3:0]  o_lease_slot;

    int          replies_pending;
    int          fault_count;
    int          stall_cycles;

    // Stimulus-side view of the registers, used only to aim requests.
    logic [31:0] cur_server;
    logic [4:0]  cur_count;
    logic [47:0] mac_pool [6];
    logic [31:0] clock_ms;
    logic        idle_on;

    dhcp_lease_allocator #(
        .MAX_LEASES(MAX_LEASES),
        .BASE_OCTET(BASE_OCTET)
    ) dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_msg_type        (i_msg_type),
        .i_has_requested_ip(i_has_requested_ip),
        .i_requested_ip    (i_requested_ip),
        .i_client_mac      (i_client_mac),
        .i_now_ms          (i_now_ms),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .o_valid           (o_valid),
        .o_reply_kind      (o_reply_kind),
        .o_assigned_ip     (o_assigned_ip),
        .o_lease_slot      (o_lease_slot)
    );

    dla_reply_checker #(
        .MAX_LEASES(MAX_LEASES),
        .BASE_OCTET(BASE_OCTET)
    ) checker_i (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (start),
        .i_busy            (busy),
        .i_msg_type        (i_msg_type),
        .i_has_requested_ip(i_has_requested_ip),
        .i_requested_ip    (i_requested_ip),
        .i_client_mac      (i_client_mac),
        .i_now_ms          (i_now_ms),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_valid           (o_valid),
        .i_reply_kind      (o_reply_kind),
        .i_assigned_ip     (o_assigned_ip),
        .i_lease_slot      (o_lease_slot),
        .o_pending         (replies_pending),
        .o_errors          (fault_count)
    );

    always #5 i_clk = ~i_clk;

    // Watchdog: reset the count on every accepted request or reply.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_valid) stall_cycles <= 0;
            else stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("[dhcp_lease_allocator] ERROR");
                $finish;
            end
        end
    end

    function automatic logic [47:0] rand_mac();
        return {16'($urandom), 32'($urandom)};
    endfunction

    // Present one request after a random gap if idle_on; keep start high across
    // back-to-back requests and hold the fields until the block takes it.
    task automatic issue_request(input logic [7:0] msg, input logic has_ip,
                                 input logic [31:0] req, input logic [47:0] mac,
                                 input logic [31:0] now);
        int gap;
        gap = idle_on ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start              <= 1'b1;
        i_msg_type         <= msg;
        i_has_requested_ip <= has_ip;
        i_requested_ip     <= req;
        i_client_mac       <= mac;
        i_now_ms           <= now;
        do @(posedge i_clk); while (busy);
    endtask

    // Drop start and wait until every reply is back and the block is idle.
    task automatic drain();
        start <= 1'b0;
        do @(posedge i_clk); while (replies_pending != 0 || busy);
    endtask

    // Write one register, only from an idle block.
    task automatic write_reg(input logic idx, input logic [31:0] data);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        if (idx == dla_pkg::REG_SERVER_IP) cur_server = data;
        else cur_count = data[4:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // One random message: mostly discovers and requests aimed at the served
    // subnet and the active slots from a small client pool, so that slots get
    // claimed, renewed, contested and left to lapse; the rest is noise.
    task automatic random_request();
        int unsigned n;
        int unsigned pick;
        logic [7:0]  msg;
        logic [7:0]  oct;
        logic        has_ip;
        logic [31:0] req;
        logic [47:0] mac;
        if ($urandom_range(0, 39) == 0) idle_on = !idle_on;
        // Advance time: mostly small steps, sometimes past lease lifetimes.
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: clock_ms += $urandom_range(0, 5000);
            6, 7:             clock_ms += $urandom_range(0, 1 << 20);
            8:                clock_ms += $urandom_range(1 << 21, 1 << 23);
            default:          clock_ms  = $urandom;
        endcase
        n = (cur_count == 0) ? 1 : ((cur_count > MAX_LEASES) ? MAX_LEASES : cur_count);
        pick = $urandom_range(0, 99);
        if (pick < 42) begin
            msg    = dla_pkg::MSG_DISCOVER;
            has_ip = ($urandom_range(0, 9) < 7);
        end else if (pick < 84) begin
            msg    = dla_pkg::MSG_REQUEST;
            has_ip = ($urandom_range(0, 99) < 92);
        end else begin
            msg    = 8'($urandom);
            has_ip = 1'($urandom);
        end
        oct = ($urandom_range(0, 4) == 0) ? 8'($urandom)
                                          : 8'(BASE_OCTET + $urandom_range(0, n));
        req = ($urandom_range(0, 6) == 0) ? $urandom : {cur_server[31:8], oct};
        mac = ($urandom_range(0, 9) == 0) ? rand_mac() : mac_pool[$urandom_range(0, 5)];
        issue_request(msg, has_ip, req, mac, clock_ms);
    endtask

    initial begin
        logic [31:0] srv;
        logic [4:0]  cnt;
        i_rst_n            = 1'b0;
        start              = 1'b0;
        i_msg_type         = '0;
        i_has_requested_ip = 1'b0;
        i_requested_ip     = '0;
        i_client_mac       = '0;
        i_now_ms           = '0;
        i_cfg_we           = 1'b0;
        i_cfg_idx          = dla_pkg::REG_SERVER_IP;
        i_cfg_data         = '0;
        cur_server         = dla_pkg::SERVER_IP_RST;
        cur_count          = dla_pkg::LEASE_COUNT_RST;
        clock_ms           = '0;
        idle_on            = 1'b1;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part under the reset registers (192.168.1.1, 16 slots).
        // Free table: offer slot 0, then claim it and renew it.
        issue_request(dla_pkg::MSG_DISCOVER, 1'b0, 32'h0, MAC_A, 32'd0);
        issue_request(dla_pkg::MSG_REQUEST, 1'b1, 32'hC0A8_0110, MAC_A, 32'd0);
        issue_request(dla_pkg::MSG_REQUEST, 1'b1, 32'hC0A8_0110, MAC_A, 32'd5000);
        // Slot taken and nothing lapsed yet: the scan finds nothing, nak.
        issue_request(dla_pkg::MSG_DISCOVER, 1'b1, 32'hC0A8_0110, MAC_B, 32'd1000);
        // Later on, free slots count as lapsed: the scan offers slot 1.
        issue_request(dla_pkg::MSG_DISCOVER, 1'b1, 32'hC0A8_0110, MAC_B, 32'h0010_0000);
        issue_request(dla_pkg::MSG_REQUEST, 1'b1, 32'hC0A8_0111, MAC_B, 32'h0010_0000);
        // Refused requests: foreign owner, no IP, foreign subnet, octet below
        // the base (wraps high), slot past the count, top octet.
        issue_request(dla_pkg::MSG_REQUEST, 1'b1, 32'hC0A8_0111, MAC_C, 32'h0010_0000);
        issue_request(dla_pkg::MSG_REQUEST, 1'b0, 32'hC0A8_0112, MAC_C, 32'h0010_0000);
        issue_request(dla_pkg::MSG_REQUEST, 1'b1, 32'h0A00_0012, MAC_C, 32'h0010_0000);
        issue_request(dla_pkg::MSG_REQUEST, 1'b1, 32'hC0A8_0105, MAC_C, 32'h0010_0000);
        issue_request(dla_pkg::MSG_REQUEST, 1'b1, 32'hC0A8_0120, MAC_C, 32'h0010_0000);
        issue_request(dla_pkg::MSG_REQUEST, 1'b1, 32'hC0A8_01FF, MAC_C, 32'h0010_0000);
        // Discover with an out-of-range and a below-base octet: fall back to
        // slot 0, which is taken, so scan.
        issue_request(dla_pkg::MSG_DISCOVER, 1'b1, 32'hC0A8_01C8, MAC_C, 32'h0010_0000);
        issue_request(dla_pkg::MSG_DISCOVER, 1'b1, 32'hC0A8_010A, MAC_B, 32'h0010_0000);
        // Other message types are refused without touching the table.
        issue_request(8'd0, 1'b1, 32'hC0A8_0110, MAC_A, 32'h0010_0000);
        issue_request(8'd2, 1'b1, 32'hC0A8_0110, MAC_A, 32'h0010_0000);
        issue_request(8'd5, 1'b0, 32'hC0A8_0110, MAC_A, 32'h0010_0000);
        issue_request(8'hFF, 1'b1, 32'hFFFF_FFFF, MAC_A, 32'h0010_0000);
        // All-zero MAC at the top of time; its request wraps the expiry.
        issue_request(dla_pkg::MSG_DISCOVER, 1'b0, 32'hFFFF_FFFF, 48'h0, 32'hFFFF_FFFF);
        issue_request(dla_pkg::MSG_REQUEST, 1'b1, 32'hC0A8_0113, 48'h0, 32'hFFFF_FFFF);
        // Much later: slot 0 has lapsed, so the scan reclaims it.
        issue_request(dla_pkg::MSG_DISCOVER, 1'b1, 32'hC0A8_0110, MAC_C, 32'h8000_0000);
        // Server last octet zero: a passing request claims but still naks.
        write_reg(dla_pkg::REG_SERVER_IP, 32'hC0A8_0100);
        issue_request(dla_pkg::MSG_REQUEST, 1'b1, 32'hC0A8_0114, MAC_C, 32'h8000_0000);
        issue_request(dla_pkg::MSG_REQUEST, 1'b1, 32'hC0A8_0114, MAC_C, 32'h8000_1000);
        issue_request(dla_pkg::MSG_DISCOVER, 1'b1, 32'hC0A8_0114, MAC_C, 32'h8000_1000);

        // Random phases, each under its own register setting.
        clock_ms = 32'h8000_1000;
        for (int p = 0; p < 8; p++) begin
            case (p)
                0:       begin srv = dla_pkg::SERVER_IP_RST;    cnt = 5'd16; end
                1:       begin srv = $urandom | 32'h1;          cnt = 5'd1;  end
                2:       begin srv = 32'hFFFF_FFFF;             cnt = 5'd0;  end
                3:       begin srv = $urandom;                  cnt = 5'd4;  end
                4:       begin srv = 32'h0000_0000;             cnt = 5'd31; end
                5:       begin srv = {24'($urandom), 8'd0};     cnt = 5'd8;  end
                6:       begin srv = $urandom;                  cnt = 5'd2;  end
                default: begin srv = $urandom; cnt = 5'($urandom_range(0, 31)); end
            endcase
            write_reg(dla_pkg::REG_SERVER_IP, srv);
            write_reg(dla_pkg::REG_LEASE_COUNT, {27'd0, cnt});
            for (int k = 0; k < 6; k++) mac_pool[k] = rand_mac();
            repeat (200) random_request();
        end

        // Wait for the last replies, then give the scan time to show strays.
        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fault_count == 0 && replies_pending == 0) begin
            $display("[dhcp_lease_allocator] OK");
        end else begin
            $display("[dhcp_lease_allocator] ERROR");
        end
        $finish;
    end

endmodule
